@@ sv/kt_pkg.sv @@
// Shared types, constants and helpers for the Kalman tilt filter.
package kt_pkg;

  localparam int unsigned CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_TIME_STEP = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_NOISE = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BIAS_NOISE = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MEASURE_NOISE = 8'd3;

  localparam logic [23:0] TIME_STEP_RST = 24'd419430;
  localparam logic [30:0] ANGLE_NOISE_RST = 31'd16777;
  localparam logic [30:0] BIAS_NOISE_RST = 31'd50332;
  localparam logic [30:0] MEASURE_NOISE_RST = 31'd503316;
  localparam logic signed [31:0] ONE_Q24 = 32'sh0100_0000;

  localparam int unsigned NUM_W = 56;
  localparam int unsigned DEN_W = 34;

  typedef enum logic [4:0] {
    CMD_NOP, CMD_LOAD, CMD_RATE, CMD_M_DT_RATE, CMD_ANG_P, CMD_M_DT_PBB, CMD_S,
    CMD_M_S_HI, CMD_M_S_LO, CMD_PRED, CMD_DEN, CMD_DIV0, CMD_K0, CMD_DIV1, CMD_K1,
    CMD_Y, CMD_M_K0Y, CMD_ANG_C, CMD_M_K1Y, CMD_BIA_C, CMD_M_K1PAA, CMD_W_PBA,
    CMD_M_K0PAA, CMD_W_PAA, CMD_M_K1PAB, CMD_W_PBB, CMD_M_K0PAB, CMD_W_PAB, CMD_OUT
  } cmd_e;

  typedef struct packed {
    logic take;
    cmd_e op;
  } kt_cmd_t;

  typedef struct packed {
    logic ch_ok;
    logic den_zero;
    logic div_done;
  } kt_stat_t;

  function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
    if (v > 68'sd2147483647) begin
      return 32'sh7fff_ffff;
    end else if (v < -68'sd2147483648) begin
      return 32'sh8000_0000;
    end else begin
      return v[31:0];
    end
  endfunction

endpackage

@@ sv/kt_div.sv @@
// Radix-2 restoring divider for the gain quotients, saturated to 32 bits.
module kt_div (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic signed [kt_pkg::NUM_W-1:0]   num_i,
  input  logic signed [kt_pkg::DEN_W-1:0]   den_i,
  output logic                              done_o,
  output logic signed [31:0]                quot_o
);

  localparam int unsigned NW = kt_pkg::NUM_W;
  localparam int unsigned DW = kt_pkg::DEN_W;
  localparam logic [5:0] LAST = 6'(NW - 1);

  logic          busy_q, done_q, neg_q;
  logic [5:0]    cnt_q;
  logic [DW-1:0] rem_q, dmag_q;
  logic [NW-1:0] sh_q;
  logic signed [31:0] quot_q;

  logic [DW:0]   trial;
  logic          qbit;
  logic [DW-1:0] rem_d;
  logic [NW-1:0] sh_d;
  logic [NW-1:0] nmag;
  logic [DW-1:0] dmag;
  logic signed [31:0] quot_d;

  assign nmag = num_i[NW-1] ? NW'(-num_i) : NW'(num_i);
  assign dmag = den_i[DW-1] ? DW'(-den_i) : DW'(den_i);

  always_comb begin
    trial = {rem_q, sh_q[NW-1]};
    qbit  = (trial >= {1'b0, dmag_q});
    rem_d = qbit ? DW'(trial - {1'b0, dmag_q}) : trial[DW-1:0];
    sh_d  = {sh_q[NW-2:0], qbit};
    if (neg_q) begin
      quot_d = (sh_d > NW'(64'h8000_0000)) ? 32'sh8000_0000 : 32'(-$signed({1'b0, sh_d}));
    end else begin
      quot_d = (sh_d > NW'(64'h7fff_ffff)) ? 32'sh7fff_ffff : $signed(sh_d[31:0]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q == LAST) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= '0;
      sh_q   <= nmag;
      dmag_q <= dmag;
      neg_q  <= num_i[NW-1] ^ den_i[DW-1];
    end else if (busy_q) begin
      rem_q <= rem_d;
      sh_q  <= sh_d;
      if (cnt_q == LAST) begin
        quot_q <= quot_d;
      end
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

@@ sv/kt_datapath.sv @@
// Filter state, configuration registers, shared multiplier and result register.
module kt_datapath #(
  parameter int unsigned CHANNELS = 4
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  kt_pkg::kt_cmd_t                cmd_i,
  output kt_pkg::kt_stat_t               stat_o,
  input  logic [1:0]                     channel_i,
  input  logic signed [31:0]             measured_angle_i,
  input  logic signed [31:0]             gyro_rate_i,
  input  logic                           cfg_we_i,
  input  logic [kt_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [30:0]                    cfg_data_i,
  output logic [1:0]                     channel_out_o,
  output logic signed [31:0]             filtered_angle_o,
  output logic signed [31:0]             bias_estimate_o
);

  logic signed [31:0] ang_mem_q [CHANNELS];
  logic signed [31:0] bia_mem_q [CHANNELS];
  logic signed [31:0] paa_mem_q [CHANNELS];
  logic signed [31:0] pab_mem_q [CHANNELS];
  logic signed [31:0] pba_mem_q [CHANNELS];
  logic signed [31:0] pbb_mem_q [CHANNELS];

  logic [23:0] dt_q;
  logic [30:0] apn_q, bpn_q, mn_q;

  logic [1:0]         ch_q, out_ch_q;
  logic signed [31:0] meas_q, gyro_q, ang_q, bia_q, paa_q, pab_q, pba_q, pbb_q;
  logic signed [31:0] rate_q, y_q, k0_q, k1_q, dtpbb_q, out_ang_q, out_bia_q;
  logic signed [35:0] s_q;
  logic signed [33:0] den_q;
  logic signed [65:0] p_q, acc_q;

  logic signed [32:0] ma, mb, dt_s;
  logic signed [65:0] prod, fm, sum24;
  logic signed [31:0] rd_ang, rd_bia, rd_paa, rd_pab, rd_pba, rd_pbb;
  logic               ch_ok, div_start, div_done;
  logic signed [kt_pkg::NUM_W-1:0] div_num;
  logic signed [31:0] quot;

  assign ch_ok = (32'(ch_q) < CHANNELS);
  assign dt_s  = $signed({9'b0, dt_q});
  assign fm    = p_q >>> 24;
  assign sum24 = (acc_q + p_q) >>> 24;

  always_comb begin
    rd_ang = '0;
    rd_bia = '0;
    rd_paa = '0;
    rd_pab = '0;
    rd_pba = '0;
    rd_pbb = '0;
    for (int i = 0; i < CHANNELS; i++) begin
      if (32'(ch_q) == i) begin
        rd_ang = ang_mem_q[i];
        rd_bia = bia_mem_q[i];
        rd_paa = paa_mem_q[i];
        rd_pab = pab_mem_q[i];
        rd_pba = pba_mem_q[i];
        rd_pbb = pbb_mem_q[i];
      end
    end
  end

  always_comb begin
    ma = '0;
    mb = '0;
    case (cmd_i.op)
      kt_pkg::CMD_M_DT_RATE: begin ma = dt_s; mb = 33'(rate_q); end
      kt_pkg::CMD_M_DT_PBB:  begin ma = dt_s; mb = 33'(pbb_q); end
      kt_pkg::CMD_M_S_HI:    begin ma = dt_s; mb = 33'($signed(s_q[35:16])); end
      kt_pkg::CMD_M_S_LO:    begin ma = dt_s; mb = $signed({17'b0, s_q[15:0]}); end
      kt_pkg::CMD_M_K0Y:     begin ma = 33'(k0_q); mb = 33'(y_q); end
      kt_pkg::CMD_M_K1Y:     begin ma = 33'(k1_q); mb = 33'(y_q); end
      kt_pkg::CMD_M_K1PAA:   begin ma = 33'(k1_q); mb = 33'(paa_q); end
      kt_pkg::CMD_M_K0PAA:   begin ma = 33'(k0_q); mb = 33'(paa_q); end
      kt_pkg::CMD_M_K1PAB:   begin ma = 33'(k1_q); mb = 33'(pab_q); end
      kt_pkg::CMD_M_K0PAB:   begin ma = 33'(k0_q); mb = 33'(pab_q); end
      default: begin ma = '0; mb = '0; end
    endcase
  end

  assign prod = ma * mb;

  assign div_start = ((cmd_i.op == kt_pkg::CMD_DIV0) || (cmd_i.op == kt_pkg::CMD_DIV1))
                     && (den_q != '0);
  assign div_num = (cmd_i.op == kt_pkg::CMD_DIV1) ? $signed({pba_q, 24'b0})
                                                  : $signed({paa_q, 24'b0});

  kt_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (den_q),
    .done_o  (div_done),
    .quot_o  (quot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dt_q  <= kt_pkg::TIME_STEP_RST;
      apn_q <= kt_pkg::ANGLE_NOISE_RST;
      bpn_q <= kt_pkg::BIAS_NOISE_RST;
      mn_q  <= kt_pkg::MEASURE_NOISE_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        kt_pkg::CFG_TIME_STEP:     dt_q  <= cfg_data_i[23:0];
        kt_pkg::CFG_ANGLE_NOISE:   apn_q <= cfg_data_i;
        kt_pkg::CFG_BIAS_NOISE:    bpn_q <= cfg_data_i;
        kt_pkg::CFG_MEASURE_NOISE: mn_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CHANNELS; i++) begin
        ang_mem_q[i] <= '0;
        bia_mem_q[i] <= '0;
        paa_mem_q[i] <= kt_pkg::ONE_Q24;
        pab_mem_q[i] <= '0;
        pba_mem_q[i] <= '0;
        pbb_mem_q[i] <= kt_pkg::ONE_Q24;
      end
    end else if (cmd_i.op == kt_pkg::CMD_OUT) begin
      for (int i = 0; i < CHANNELS; i++) begin
        if (32'(ch_q) == i) begin
          ang_mem_q[i] <= ang_q;
          bia_mem_q[i] <= bia_q;
          paa_mem_q[i] <= paa_q;
          pab_mem_q[i] <= pab_q;
          pba_mem_q[i] <= pba_q;
          pbb_mem_q[i] <= pbb_q;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    p_q <= prod;
    if (cmd_i.take) begin
      ch_q   <= channel_i;
      meas_q <= measured_angle_i;
      gyro_q <= gyro_rate_i;
    end
    case (cmd_i.op)
      kt_pkg::CMD_LOAD: begin
        ang_q <= rd_ang;
        bia_q <= rd_bia;
        paa_q <= rd_paa;
        pab_q <= rd_pab;
        pba_q <= rd_pba;
        pbb_q <= rd_pbb;
      end
      kt_pkg::CMD_RATE:  rate_q <= kt_pkg::sat32(68'(gyro_q) - 68'(bia_q));
      kt_pkg::CMD_ANG_P: ang_q <= kt_pkg::sat32(68'(ang_q) + 68'(fm));
      kt_pkg::CMD_S: begin
        dtpbb_q <= fm[31:0];
        s_q <= 36'(fm) - 36'(pab_q) - 36'(pba_q) + $signed({5'b0, apn_q});
      end
      kt_pkg::CMD_M_S_LO: acc_q <= p_q <<< 16;
      kt_pkg::CMD_PRED: begin
        paa_q <= kt_pkg::sat32(68'(paa_q) + 68'(sum24));
        pab_q <= kt_pkg::sat32(68'(pab_q) - 68'(dtpbb_q));
        pba_q <= kt_pkg::sat32(68'(pba_q) - 68'(dtpbb_q));
        pbb_q <= kt_pkg::sat32(68'(pbb_q) + $signed({37'b0, bpn_q}));
      end
      kt_pkg::CMD_DEN: begin
        den_q <= 34'(paa_q) + $signed({3'b0, mn_q});
        k0_q  <= '0;
        k1_q  <= '0;
      end
      kt_pkg::CMD_K0:    k0_q <= quot;
      kt_pkg::CMD_K1:    k1_q <= quot;
      kt_pkg::CMD_Y:     y_q <= kt_pkg::sat32(68'(meas_q) - 68'(ang_q));
      kt_pkg::CMD_ANG_C: ang_q <= kt_pkg::sat32(68'(ang_q) + 68'(fm));
      kt_pkg::CMD_BIA_C: bia_q <= kt_pkg::sat32(68'(bia_q) + 68'(fm));
      kt_pkg::CMD_W_PBA: pba_q <= kt_pkg::sat32(68'(pba_q) - 68'(fm));
      kt_pkg::CMD_W_PAA: paa_q <= kt_pkg::sat32(68'(paa_q) - 68'(fm));
      kt_pkg::CMD_W_PBB: pbb_q <= kt_pkg::sat32(68'(pbb_q) - 68'(fm));
      kt_pkg::CMD_W_PAB: pab_q <= kt_pkg::sat32(68'(pab_q) - 68'(fm));
      kt_pkg::CMD_OUT: begin
        out_ch_q  <= ch_q;
        out_ang_q <= ch_ok ? ang_q : '0;
        out_bia_q <= ch_ok ? bia_q : '0;
      end
      default: ;
    endcase
  end

  assign stat_o.ch_ok    = ch_ok;
  assign stat_o.den_zero = (den_q == '0);
  assign stat_o.div_done = div_done;

  assign channel_out_o    = out_ch_q;
  assign filtered_angle_o = out_ang_q;
  assign bias_estimate_o  = out_bia_q;

endmodule

@@ sv/kt_ctrl.sv @@
// Sequencer that steps the datapath through one filter update per request.
module kt_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  kt_pkg::kt_stat_t  stat_i,
  output kt_pkg::kt_cmd_t   cmd_o
);

  typedef enum logic [1:0] {S_IDLE, S_RUN, S_DIV, S_HOLD} state_e;

  state_e         state_q;
  kt_pkg::cmd_e   op_q, op_nxt;
  logic           out_valid_q;

  assign op_nxt = kt_pkg::cmd_e'(5'(op_q) + 5'd1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      op_q        <= kt_pkg::CMD_NOP;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            state_q <= S_RUN;
            op_q    <= kt_pkg::CMD_LOAD;
          end
        end
        S_RUN: begin
          if (op_q == kt_pkg::CMD_OUT) begin
            state_q     <= S_IDLE;
            out_valid_q <= 1'b1;
          end else if (op_q == kt_pkg::CMD_LOAD && !stat_i.ch_ok) begin
            op_q    <= kt_pkg::CMD_OUT;
            state_q <= S_HOLD;
          end else if (op_q == kt_pkg::CMD_DIV0 && stat_i.den_zero) begin
            op_q <= kt_pkg::CMD_Y;
          end else begin
            op_q <= op_nxt;
            if (op_q == kt_pkg::CMD_DIV0 || op_q == kt_pkg::CMD_DIV1) begin
              state_q <= S_DIV;
            end else if (op_nxt == kt_pkg::CMD_OUT) begin
              state_q <= S_HOLD;
            end
          end
        end
        S_DIV: begin
          if (stat_i.div_done) begin
            state_q <= S_RUN;
          end
        end
        S_HOLD: begin
          if (!out_valid_q || out_ready_i) begin
            state_q <= S_RUN;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign cmd_o.take  = in_valid_i && (state_q == S_IDLE);
  assign cmd_o.op    = (state_q == S_RUN) ? op_q : kt_pkg::CMD_NOP;

endmodule

@@ sv/kalman_tilt_angle_filter_core.sv @@
// Top level of the multi-channel angle and gyro bias Kalman filter.
//
// Channel  Direction  Handshake              Payload
// in       input      in_valid_i/in_ready_o  channel_i, measured_angle_i, gyro_rate_i
// out      output     out_valid_o/out_ready_i channel_out_o, filtered_angle_o, bias_estimate_o
// cfg      input      cfg_we_i               cfg_idx_i, cfg_data_i
//
// One request runs from its acceptance in the idle state through 28 sequencer steps on the
// shared 33 by 33 multiplier, a hold state ahead of the result write and two waits on the
// bit-serial gain divider.
// A zero innovation variance skips both divisions; a channel beyond the configured count
// goes straight to the result register.
// Reset restores every channel to zero angle and bias with unit covariance.
// A waiting result holds the sequencer only at its final write; the next request is taken
// once that result has been written to the output register.
module kalman_tilt_angle_filter_core #(
  parameter int unsigned CHANNELS = 4
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [1:0]                    channel_i,
  input  logic signed [31:0]            measured_angle_i,
  input  logic signed [31:0]            gyro_rate_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [1:0]                    channel_out_o,
  output logic signed [31:0]            filtered_angle_o,
  output logic signed [31:0]            bias_estimate_o,
  input  logic                          cfg_we_i,
  input  logic [kt_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [30:0]                   cfg_data_i
);

  kt_pkg::kt_cmd_t  cmd;
  kt_pkg::kt_stat_t stat;

  kt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  kt_datapath #(
    .CHANNELS (CHANNELS)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .channel_i        (channel_i),
    .measured_angle_i (measured_angle_i),
    .gyro_rate_i      (gyro_rate_i),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .channel_out_o    (channel_out_o),
    .filtered_angle_o (filtered_angle_o),
    .bias_estimate_o  (bias_estimate_o)
  );

`ifndef SYNTHESIS
  a_busy_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("request taken while a filter update was running");

  a_bad_channel_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (32'(channel_out_o) >= CHANNELS)) |->
    (filtered_angle_o == '0 && bias_estimate_o == '0))
    else $error("result for an absent channel is not zero");

  a_result_after_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result appeared without a filter update");
`endif

endmodule
